// File: hw/rtl/float32_exp10_core_defines.svh
// Assertion macros shared by the exponent core.
`ifndef FLOAT32_EXP10_CORE_DEFINES_SVH
`define FLOAT32_EXP10_CORE_DEFINES_SVH
// Same-cycle implication, sampled on the rising edge of clk outside reset.
`define E10_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on the rising edge of clk outside reset.
`define E10_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: hw/rtl/e10_pkg.sv
// Shared types, constants and helper functions of the exponent core.
`default_nettype none
package e10_pkg;

    // Sideband word that travels with every operand through the pipeline.
    typedef struct packed {
        logic               vld;
        logic               spec;
        logic [31:0]        sval;
        logic signed [8:0]  n;
        logic [63:0]        r;
        logic [63:0]        aux;
    } e10_side_t;

    // Double-precision constants of the range reduction.
    localparam logic [63:0] LOG2_10 = $realtobits(3.321928094887362);
    localparam logic [63:0] LG2_HI  = $realtobits(0.3010299956640665);
    localparam logic [63:0] LG2_LO  = $realtobits(-8.532344317057107e-14);

    // Polynomial coefficients, constant term first.
    localparam logic [63:0] POLY_COEF [11] = '{
        $realtobits(1.0),
        $realtobits(2.3025850929940486),
        $realtobits(2.6509490552392045),
        $realtobits(2.034678592287247),
        $realtobits(1.171255148908203),
        $realtobits(5.393829313950126e-1),
        $realtobits(2.0699584957469658e-1),
        $realtobits(6.808909329404776e-2),
        $realtobits(1.959761565686179e-2),
        $realtobits(5.027633471110143e-3),
        $realtobits(1.1576553790747818e-3)
    };

    // Single-precision thresholds and fixed result patterns.
    localparam logic [30:0] UFL_MAG  = 31'h4235d277;
    localparam logic [30:0] OFL_MAG  = 31'h421a209b;
    localparam logic [31:0] INF_BITS = 32'h7f800000;
    localparam logic [31:0] ZERO_BITS = 32'h00000000;

    // Count of leading zeros in a 64-bit word (64 when the word is zero).
    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] c;
        logic       found;
        c = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && v[i]) begin
                c = 7'(63 - i);
                found = 1'b1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/e10_fmul.sv
// Three-stage double-precision multiplier, round to nearest even.
`default_nettype none
module e10_fmul
    import e10_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  e10_side_t   side_in,
    output logic [63:0] prod,
    output e10_side_t   side_out
);

    logic [52:0]  ma;
    logic [52:0]  mb;
    logic [51:0]  hh_next;
    logic [52:0]  hl_next;
    logic [52:0]  lh_next;
    logic [53:0]  ll_next;
    logic [51:0]  hh_reg;
    logic [52:0]  hl_reg;
    logic [52:0]  lh_reg;
    logic [53:0]  ll_reg;
    logic         s1_sign_reg;
    logic [11:0]  s1_exp_reg;
    logic         s1_zero_reg;
    e10_side_t    s1_side_reg;

    logic [53:0]  mid;
    logic [105:0] sum_next;
    logic [105:0] sum_reg;
    logic         s2_sign_reg;
    logic [11:0]  s2_exp_reg;
    logic         s2_zero_reg;
    e10_side_t    s2_side_reg;

    logic         top;
    logic [52:0]  mant;
    logic         grd;
    logic         stk;
    logic         up;
    logic [53:0]  m54;
    logic [12:0]  e13;
    logic [63:0]  prod_next;
    logic [63:0]  prod_reg;
    e10_side_t    s3_side_reg;

    // Stage one: four partial products of the split significands.
    always_comb
    begin
        ma = {a[62:52] != 11'd0, a[51:0]};
        mb = {b[62:52] != 11'd0, b[51:0]};
        hh_next = ma[52:27] * mb[52:27];
        hl_next = ma[52:27] * mb[26:0];
        lh_next = ma[26:0] * mb[52:27];
        ll_next = ma[26:0] * mb[26:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg      <= hh_next;
            hl_reg      <= hl_next;
            lh_reg      <= lh_next;
            ll_reg      <= ll_next;
            s1_sign_reg <= a[63] ^ b[63];
            s1_exp_reg  <= {1'b0, a[62:52]} + {1'b0, b[62:52]};
            s1_zero_reg <= (a[62:52] == 11'd0) || (b[62:52] == 11'd0);
        end
    end

    // Stage two: sum of the partial products.
    always_comb
    begin
        mid = {1'b0, hl_reg} + {1'b0, lh_reg};
        sum_next = {hh_reg, 54'd0} + {25'd0, mid, 27'd0} + {52'd0, ll_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg     <= sum_next;
            s2_sign_reg <= s1_sign_reg;
            s2_exp_reg  <= s1_exp_reg;
            s2_zero_reg <= s1_zero_reg;
        end
    end

    // Stage three: normalise by at most one place and round.
    always_comb
    begin
        top  = sum_reg[105];
        mant = top ? sum_reg[105:53] : sum_reg[104:52];
        grd  = top ? sum_reg[52] : sum_reg[51];
        stk  = top ? (|sum_reg[51:0]) : (|sum_reg[50:0]);
        up   = grd & (stk | mant[0]);
        m54  = {1'b0, mant} + {53'd0, up};
        e13  = {1'b0, s2_exp_reg} - 13'd1023 + {12'd0, top} + {12'd0, m54[53]};
        if (s2_zero_reg)
        begin
            prod_next = {s2_sign_reg, 63'd0};
        end
        else
        begin
            prod_next = {s2_sign_reg, e13[10:0], m54[53] ? 52'd0 : m54[51:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    // Sideband words follow the data stage by stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg <= '0;
            s2_side_reg <= '0;
            s3_side_reg <= '0;
        end
        else if (en)
        begin
            s1_side_reg <= side_in;
            s2_side_reg <= s1_side_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    assign prod     = prod_reg;
    assign side_out = s3_side_reg;

endmodule
`default_nettype wire

// File: hw/rtl/e10_fadd.sv
// Four-stage double-precision adder, round to nearest even.
`default_nettype none
module e10_fadd
    import e10_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  e10_side_t   side_in,
    output logic [63:0] sum,
    output e10_side_t   side_out
);

    logic         a_big;
    logic [63:0]  big_reg;
    logic [63:0]  sml_reg;
    logic [10:0]  d_reg;
    logic         zsign1_reg;
    e10_side_t    s1_side_reg;

    logic [55:0]  ms;
    logic [55:0]  al;
    logic         stk_al;
    logic [56:0]  mb57;
    logic [56:0]  add_next;
    logic [56:0]  add_reg;
    logic [10:0]  e2_reg;
    logic         sign2_reg;
    logic         zsign2_reg;
    e10_side_t    s2_side_reg;

    logic [6:0]   lz_full;
    logic [56:0]  add3_reg;
    logic [5:0]   lz_reg;
    logic [10:0]  e3_reg;
    logic         sign3_reg;
    logic         zsign3_reg;
    e10_side_t    s3_side_reg;

    logic [55:0]  nrm;
    logic [11:0]  e12;
    logic [52:0]  mant;
    logic         up;
    logic [53:0]  m54;
    logic [11:0]  e_fin;
    logic [63:0]  sum_next;
    logic [63:0]  sum_reg;
    e10_side_t    s4_side_reg;

    // Stage one: order the operands by magnitude.
    assign a_big = a[62:0] >= b[62:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_reg    <= a_big ? a : b;
            sml_reg    <= a_big ? b : a;
            d_reg      <= a_big ? (a[62:52] - b[62:52]) : (b[62:52] - a[62:52]);
            zsign1_reg <= a[63] & b[63];
        end
    end

    // Stage two: align the smaller significand and add or subtract.
    always_comb
    begin
        ms = {sml_reg[62:52] != 11'd0, sml_reg[51:0], 3'b000};
        if (d_reg >= 11'd56)
        begin
            al     = 56'd0;
            stk_al = |ms;
        end
        else
        begin
            al     = ms >> d_reg;
            stk_al = |(ms & ~({56{1'b1}} << d_reg));
        end
        al[0] = al[0] | stk_al;
        mb57 = {1'b0, big_reg[62:52] != 11'd0, big_reg[51:0], 3'b000};
        if (big_reg[63] ^ sml_reg[63])
        begin
            add_next = mb57 - {1'b0, al};
        end
        else
        begin
            add_next = mb57 + {1'b0, al};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            add_reg    <= add_next;
            e2_reg     <= big_reg[62:52];
            sign2_reg  <= big_reg[63];
            zsign2_reg <= zsign1_reg;
        end
    end

    // Stage three: leading-zero search for the normalising shift.
    assign lz_full = lzc64({add_reg[55:0], 8'hff});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            add3_reg   <= add_reg;
            lz_reg     <= lz_full[5:0];
            e3_reg     <= e2_reg;
            sign3_reg  <= sign2_reg;
            zsign3_reg <= zsign2_reg;
        end
    end

    // Stage four: normalise and round.
    always_comb
    begin
        if (add3_reg[56])
        begin
            nrm = {add3_reg[56:2], add3_reg[1] | add3_reg[0]};
            e12 = {1'b0, e3_reg} + 12'd1;
        end
        else
        begin
            nrm = add3_reg[55:0] << lz_reg;
            e12 = {1'b0, e3_reg} - {6'd0, lz_reg};
        end
        mant  = nrm[55:3];
        up    = nrm[2] & ((|nrm[1:0]) | mant[0]);
        m54   = {1'b0, mant} + {53'd0, up};
        e_fin = e12 + {11'd0, m54[53]};
        if (add3_reg == 57'd0)
        begin
            sum_next = {zsign3_reg, 63'd0};
        end
        else
        begin
            sum_next = {sign3_reg, e_fin[10:0], m54[53] ? 52'd0 : m54[51:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    // Sideband words follow the data stage by stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg <= '0;
            s2_side_reg <= '0;
            s3_side_reg <= '0;
            s4_side_reg <= '0;
        end
        else if (en)
        begin
            s1_side_reg <= side_in;
            s2_side_reg <= s1_side_reg;
            s3_side_reg <= s2_side_reg;
            s4_side_reg <= s3_side_reg;
        end
    end

    assign sum      = sum_reg;
    assign side_out = s4_side_reg;

endmodule
`default_nettype wire

// File: hw/rtl/e10_nround.sv
// Two-stage rounding of x*log2(10) to an integer and its conversion to double.
`default_nettype none
module e10_nround
    import e10_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [63:0] t,
    input  e10_side_t   side_in,
    output e10_side_t   side_out
);

    logic [10:0]       te;
    logic [63:0]       tm;
    logic [5:0]        sh;
    logic [63:0]       mask;
    logic [63:0]       half;
    logic [63:0]       rem;
    logic [8:0]        q;
    logic signed [8:0] n_next;
    e10_side_t         s1_side_next;
    e10_side_t         s1_side_reg;

    logic [8:0]        mag;
    logic [6:0]        lz;
    logic [6:0]        shl;
    logic [63:0]       fr;
    logic [63:0]       nd_next;
    e10_side_t         s2_side_next;
    e10_side_t         s2_side_reg;

    // Stage one: round to nearest integer, ties to even, symmetric in sign.
    always_comb
    begin
        te   = t[62:52];
        tm   = {11'd0, 1'b1, t[51:0]};
        sh   = 6'(11'd1075 - te);
        mask = (64'd1 << sh) - 64'd1;
        half = 64'd1 << (sh - 6'd1);
        rem  = tm & mask;
        priority if (te < 11'd1022)
        begin
            q = 9'd0;
        end
        else if (te > 11'd1030)
        begin
            q = 9'h1ff;
        end
        else
        begin
            q = 9'(tm >> sh);
            if (rem > half || (rem == half && q[0]))
            begin
                q = q + 9'd1;
            end
        end
        n_next = t[63] ? -$signed(q) : $signed(q);
        s1_side_next   = side_in;
        s1_side_next.n = n_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg <= '0;
        end
        else if (en)
        begin
            s1_side_reg <= s1_side_next;
        end
    end

    // Stage two: convert the integer to double precision.
    always_comb
    begin
        mag = s1_side_reg.n[8] ? 9'(-s1_side_reg.n) : 9'(s1_side_reg.n);
        lz  = lzc64({55'd0, mag});
        shl = lz - 7'd11;
        fr  = {55'd0, mag} << shl;
        if (mag == 9'd0)
        begin
            nd_next = {s1_side_reg.n[8], 63'd0};
        end
        else
        begin
            nd_next = {s1_side_reg.n[8], 11'(11'd1086 - {4'd0, lz}), fr[51:0]};
        end
        s2_side_next     = s1_side_reg;
        s2_side_next.aux = nd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_side_reg <= '0;
        end
        else if (en)
        begin
            s2_side_reg <= s2_side_next;
        end
    end

    assign side_out = s2_side_reg;

endmodule
`default_nettype wire

// File: hw/rtl/e10_pack.sv
// Output stage: scaling by 2^n, single-precision rounding and special results.
`default_nettype none
module e10_pack
    import e10_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [63:0] p,
    input  e10_side_t   side_in,
    output logic [31:0] res,
    output e10_side_t   side_out
);

    logic [10:0]        e_eff;
    logic [63:0]        m;
    logic signed [13:0] fe;
    logic [31:0]        base;
    logic [6:0]         sh;
    logic [63:0]        mask;
    logic [63:0]        half;
    logic [63:0]        rem;
    logic [31:0]        q;
    logic [31:0]        bits;
    logic [31:0]        res_next;
    logic [31:0]        res_reg;
    e10_side_t          side_reg;

    // Scale, round once to single and apply the special cases.
    always_comb
    begin
        e_eff = (p[62:52] == 11'd0) ? 11'd1 : p[62:52];
        m     = {11'd0, p[62:52] != 11'd0, p[51:0]};
        fe    = $signed({3'b000, e_eff}) + 14'(side_in.n) - 14'sd896;
        if (fe >= 14'sd1)
        begin
            base = {fe[8:0] - 9'd1, 23'd0};
            sh   = 7'd29;
        end
        else
        begin
            base = 32'd0;
            sh   = (fe < -14'sd30) ? 7'd61 : 7'(14'sd30 - fe);
        end
        mask = (64'd1 << sh[5:0]) - 64'd1;
        half = 64'd1 << (sh[5:0] - 6'd1);
        rem  = m & mask;
        if (sh > 7'd60)
        begin
            q = 32'd0;
        end
        else
        begin
            q = 32'(m >> sh[5:0]);
            if (rem > half || (rem == half && q[0]))
            begin
                q = q + 32'd1;
            end
        end
        bits = base + q;
        priority if (side_in.spec)
        begin
            res_next = side_in.sval;
        end
        else if (m == 64'd0)
        begin
            res_next = ZERO_BITS;
        end
        else if (fe >= 14'sd255 || bits >= INF_BITS)
        begin
            res_next = INF_BITS;
        end
        else
        begin
            res_next = bits;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    assign res      = res_reg;
    assign side_out = side_reg;

endmodule
`default_nettype wire

// File: hw/rtl/float32_exp10_core.sv
// Throughput: one word per cycle; every stage register advances together,
// and the whole pipeline holds while the output word is stalled.
// The datapath is 13 double-precision multipliers and 12 adders in series.
// Reset clears the sideband words, valid bits included, asynchronously; data registers are not reset.
`default_nettype none
`include "float32_exp10_core_defines.svh"
module float32_exp10_core
    import e10_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        operand_valid,
    output logic        operand_stall,
    input  logic [31:0] operand_bits,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] result_bits
);

    logic        adv;
    logic        x_sgn;
    logic [7:0]  x_ex;
    logic [22:0] x_fr;
    logic [6:0]  x_lz;
    logic [22:0] x_sub;
    logic [63:0] xd;
    e10_side_t   front_next;
    e10_side_t   front_reg;

    logic [63:0] t_val;
    e10_side_t   s_t;
    e10_side_t   s_n;
    logic [63:0] p1;
    e10_side_t   s_m1;
    logic [63:0] r1;
    e10_side_t   s_a1;
    e10_side_t   s_r1;
    logic [63:0] p2;
    e10_side_t   s_m2;
    logic [63:0] r2;
    e10_side_t   s_a2;

    logic [63:0] hp [0:10];
    e10_side_t   hs [0:10];
    logic [10:0] hv;
    e10_side_t   pk_side;
    logic [17:0] vld_vec;

    // The pipeline advances unless a finished word is held at the output.
    assign adv           = !(result_valid && result_stall);
    assign operand_stall = !adv;

    // Front stage: special operands and widening to double.
    always_comb
    begin
        x_sgn = operand_bits[31];
        x_ex  = operand_bits[30:23];
        x_fr  = operand_bits[22:0];
        x_lz  = lzc64({x_fr, 41'd0});
        x_sub = x_fr << (x_lz + 7'd1);
        if (x_ex == 8'd0)
        begin
            if (x_fr == 23'd0)
            begin
                xd = {x_sgn, 63'd0};
            end
            else
            begin
                xd = {x_sgn, 11'(11'd896 - {4'd0, x_lz}), x_sub, 29'd0};
            end
        end
        else
        begin
            xd = {x_sgn, {3'd0, x_ex} + 11'd896, x_fr, 29'd0};
        end
        front_next     = '0;
        front_next.vld = operand_valid;
        front_next.r   = xd;
        priority if (x_ex == 8'hff && x_fr != 23'd0)
        begin
            front_next.spec = 1'b1;
            front_next.sval = operand_bits;
        end
        else if (x_sgn && operand_bits[30:0] > UFL_MAG)
        begin
            front_next.spec = 1'b1;
            front_next.sval = ZERO_BITS;
        end
        else if (!x_sgn && operand_bits[30:0] > OFL_MAG)
        begin
            front_next.spec = 1'b1;
            front_next.sval = INF_BITS;
        end
        else
        begin
            front_next.spec = 1'b0;
            front_next.sval = ZERO_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else if (adv)
        begin
            front_reg <= front_next;
        end
    end

    // Range reduction: n from x*log2(10), then r in two Cody-Waite steps.
    e10_fmul u_mul_t (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .a(front_reg.r), .b(LOG2_10), .side_in(front_reg),
        .prod(t_val), .side_out(s_t)
    );

    e10_nround u_nround (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .t(t_val), .side_in(s_t), .side_out(s_n)
    );

    e10_fmul u_mul_hi (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .a(s_n.aux), .b(LG2_HI), .side_in(s_n),
        .prod(p1), .side_out(s_m1)
    );

    e10_fadd u_add_hi (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .a(s_m1.r), .b({~p1[63], p1[62:0]}), .side_in(s_m1),
        .sum(r1), .side_out(s_a1)
    );

    always_comb
    begin
        s_r1   = s_a1;
        s_r1.r = r1;
    end

    e10_fmul u_mul_lo (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .a(s_r1.aux), .b(LG2_LO), .side_in(s_r1),
        .prod(p2), .side_out(s_m2)
    );

    e10_fadd u_add_lo (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .a(s_m2.r), .b({~p2[63], p2[62:0]}), .side_in(s_m2),
        .sum(r2), .side_out(s_a2)
    );

    always_comb
    begin
        hs[0]   = s_a2;
        hs[0].r = r2;
    end

    assign hp[0] = POLY_COEF[10];

    // Horner steps, one multiplier and one adder per coefficient.
    for (genvar k = 0; k < 10; k++)
    begin : g_horner
        logic [63:0] mp;
        e10_side_t   ms;

        e10_fmul u_mul (
            .clk(clk), .rst_n(rst_n), .en(adv),
            .a(hp[k]), .b(hs[k].r), .side_in(hs[k]),
            .prod(mp), .side_out(ms)
        );

        e10_fadd u_add (
            .clk(clk), .rst_n(rst_n), .en(adv),
            .a(mp), .b(POLY_COEF[9 - k]), .side_in(ms),
            .sum(hp[k + 1]), .side_out(hs[k + 1])
        );
    end

    for (genvar k = 0; k < 11; k++)
    begin : g_hv
        assign hv[k] = hs[k].vld;
    end

    // Scaling by 2^n and final rounding; this register is the output.
    e10_pack u_pack (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .p(hp[10]), .side_in(hs[10]),
        .res(result_bits), .side_out(pk_side)
    );

    assign result_valid = pk_side.vld;

    assign vld_vec = {front_reg.vld, s_t.vld, s_n.vld, s_m1.vld, s_a1.vld,
                      s_m2.vld, hv, result_valid};

    // A held output freezes every valid bit in the pipeline.
    `E10_ASSERT_NEXT(a_freeze, operand_stall, $stable(vld_vec), "pipeline moved while held")
    // The polynomial value lies between one half and two for ordinary operands.
    `E10_ASSERT_NOW(a_poly_range, hs[10].vld && !hs[10].spec, hp[10][63] == 1'b0 && (hp[10][62:52] == 11'd1022 || hp[10][62:52] == 11'd1023), "polynomial value out of range")
    // An ordinary operand never yields a NaN pattern.
    `E10_ASSERT_NOW(a_no_nan, result_valid && !pk_side.spec, result_bits[30:23] != 8'hff || result_bits[22:0] == 23'd0, "NaN produced from an ordinary operand")

endmodule
`default_nettype wire
